// ===== src/sdgcp_pkg.sv =====
package sdgcp_pkg;

  localparam int PIN_COUNT_DEFAULT = 4;
  localparam int PIN_W             = 4;
  localparam int VER_W             = 7;
  localparam int DAC_BITS          = 12;
  localparam int DAC_W             = 16;
  localparam int DAC_SHIFT         = DAC_W - DAC_BITS;
  localparam int ID_LEN            = 7;
  localparam int MAX_ARGS          = 4;

  localparam logic [VER_W-1:0] FW_VERSION_RESET = VER_W'(2);

  // Command codes
  localparam logic [7:0] CMD_SET_PINS = 8'd1;
  localparam logic [7:0] CMD_GET_PINS = 8'd2;
  localparam logic [7:0] CMD_SET_DAC  = 8'd3;
  localparam logic [7:0] CMD_ID       = 8'd7;
  localparam logic [7:0] CMD_ID_ALT   = 8'd30;
  localparam logic [7:0] CMD_VERSION  = 8'd31;
  localparam logic [7:0] CMD_QUERY_40 = 8'd40;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_FOUR    = 8'h34;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam logic [7:0] ID_TEXT [ID_LEN] = '{
    8'h4d, 8'h4d, 8'h2d, 8'h41, 8'h72, 8'h64, 8'h0a
  };

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PATTERN = 3'd1,
    PH_CHANNEL = 3'd2,
    PH_HIGH    = 3'd3,
    PH_LOW     = 3'd4
  } phase_t;

  // One burst of response bytes, produced by the parser for one received byte
  typedef struct packed {
    logic [2:0]                len;
    logic                      use_id;
    logic                      dac_write;
    logic [7:0]                dac_channel;
    logic [DAC_W-1:0]          dac_value;
    logic [PIN_W-1:0]          pins;
    logic [MAX_ARGS-1:0][7:0]  bytes;
  } burst_t;

endpackage

// ===== src/sdgcp_ifs.sv =====
interface sdgcp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sdgcp_tx_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        dac_write;
  logic [7:0]  dac_channel;
  logic [15:0] dac_value;
  logic [3:0]  pin_pattern;
  logic        last;

  modport source (output valid, output tx_valid, output tx_byte, output dac_write,
                  output dac_channel, output dac_value, output pin_pattern,
                  output last, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input dac_write,
                input dac_channel, input dac_value, input pin_pattern,
                input last, output ready);
endinterface

// ===== src/sdgcp_parser.sv =====
module sdgcp_parser
  import sdgcp_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic [VER_W-1:0] fw_version,
  output burst_t           burst
);

  localparam logic [PIN_W-1:0] PinMask =
    (PIN_COUNT >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((1 << PIN_COUNT) - 1);

  phase_t     phase_r, phase_nxt;
  logic [7:0] pattern_r, pattern_nxt;
  logic [7:0] channel_r, channel_nxt;
  logic [7:0] high_r, high_nxt;

  // Decimal digits of the version (at most 127)
  logic [14:0] ver_prod;
  logic [3:0]  tens_all;
  logic [7:0]  tens_x10;
  logic [3:0]  ones;
  logic        has_hundreds;
  logic        has_tens;
  logic [3:0]  tens;

  assign ver_prod     = 15'(fw_version) * 15'd205;
  assign tens_all     = ver_prod[14:11];
  assign tens_x10     = 8'(tens_all) * 8'd10;
  assign ones         = 4'(8'(fw_version) - tens_x10);
  assign has_hundreds = (fw_version >= VER_W'(100));
  assign has_tens     = (fw_version >= VER_W'(10));
  assign tens         = has_hundreds ? (tens_all - 4'd10) : tens_all;

  // Next phase
  always_comb begin
    phase_nxt = PH_IDLE;
    case (phase_r)
      PH_PATTERN: phase_nxt = PH_IDLE;
      PH_CHANNEL: phase_nxt = PH_HIGH;
      PH_HIGH:    phase_nxt = PH_LOW;
      PH_LOW:     phase_nxt = PH_IDLE;
      default: begin
        case (rx_byte)
          CMD_SET_PINS: phase_nxt = PH_PATTERN;
          CMD_SET_DAC:  phase_nxt = PH_CHANNEL;
          default:      phase_nxt = PH_IDLE;
        endcase
      end
    endcase
  end

  // Held arguments and the response burst
  always_comb begin
    pattern_nxt = pattern_r;
    channel_nxt = channel_r;
    high_nxt    = high_r;
    burst       = '0;
    case (phase_r)
      PH_PATTERN: begin
        pattern_nxt    = rx_byte;
        burst.len      = 3'd1;
        burst.bytes[0] = CMD_SET_PINS;
      end
      PH_CHANNEL: channel_nxt = rx_byte;
      PH_HIGH:    high_nxt = rx_byte;
      PH_LOW: begin
        burst.len         = 3'd4;
        burst.dac_write   = 1'b1;
        burst.dac_channel = channel_r;
        burst.dac_value   = DAC_W'({high_r, rx_byte} << DAC_SHIFT);
        burst.bytes[0]    = CMD_SET_DAC;
        burst.bytes[1]    = channel_r;
        burst.bytes[2]    = high_r;
        burst.bytes[3]    = rx_byte;
      end
      default: begin
        case (rx_byte)
          CMD_GET_PINS: begin
            burst.len      = 3'd2;
            burst.bytes[0] = CMD_GET_PINS;
            burst.bytes[1] = pattern_r;
          end
          CMD_ID, CMD_ID_ALT: begin
            burst.len    = 3'(ID_LEN);
            burst.use_id = 1'b1;
          end
          CMD_VERSION: begin
            if (has_hundreds) begin
              burst.len      = 3'd4;
              burst.bytes[0] = CH_ZERO + 8'd1;
              burst.bytes[1] = CH_ZERO + 8'(tens);
              burst.bytes[2] = CH_ZERO + 8'(ones);
              burst.bytes[3] = CH_NEWLINE;
            end else if (has_tens) begin
              burst.len      = 3'd3;
              burst.bytes[0] = CH_ZERO + 8'(tens);
              burst.bytes[1] = CH_ZERO + 8'(ones);
              burst.bytes[2] = CH_NEWLINE;
            end else begin
              burst.len      = 3'd2;
              burst.bytes[0] = CH_ZERO + 8'(ones);
              burst.bytes[1] = CH_NEWLINE;
            end
          end
          CMD_QUERY_40: begin
            burst.len      = 3'd2;
            burst.bytes[0] = CH_FOUR;
            burst.bytes[1] = CH_ZERO;
          end
          default: burst.len = 3'd0;
        endcase
      end
    endcase
    burst.pins = pattern_nxt[PIN_W-1:0] & PinMask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pattern_r <= '0;
      channel_r <= '0;
      high_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pattern_r <= pattern_nxt;
      channel_r <= channel_nxt;
      high_r    <= high_nxt;
    end
  end

endmodule

// ===== src/serial_dac_gpio_command_parser_top.sv =====
// Serial command parser with a digital pin port and a DAC write port. Feed it
// received serial bytes on in_chan, one transfer per byte; each byte yields
// zero to seven response transfers on out_chan, the final one marked by last.
// Command 1 (pattern byte follows) sets the pins and echoes 1; command 2
// echoes 2 and the stored pattern; command 3 (channel, high, low bytes follow)
// issues one DAC write of the 12-bit value shifted up by four, carried on the
// first of four echo transfers; commands 7 and 30 return the identification
// text; command 31 returns cfg_wdata's stored version in decimal and a newline;
// command 40 returns "40"; other bytes are dropped. Rate: a byte is taken when
// the burst stage is free, and a byte with several responses holds the input
// until its last is loaded, as the response sequencer sends one transfer a
// cycle to the output register unless stalled, so bytes causing at most
// one response stream at one per cycle. Write cfg only while the block is idle.
module serial_dac_gpio_command_parser_top
  import sdgcp_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  sdgcp_rx_if.sink          in_chan,
  sdgcp_tx_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [VER_W-1:0]  cfg_wdata
);

  logic [VER_W-1:0] version_r;

  // Burst stage: the responses still owed for the last accepted byte
  burst_t     burst_nxt;
  burst_t     burst_r;
  logic       busy_r;
  logic [2:0] idx_r;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_dac_r;
  logic [7:0]  out_chan_r;
  logic [15:0] out_value_r;
  logic [3:0]  out_pins_r;
  logic        out_last_r;

  logic       in_accept;
  logic       load;
  logic       final_load;
  logic [7:0] sel_byte;

  // Version register: to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= FW_VERSION_RESET;
    end else if (cfg_we) begin
      version_r <= cfg_wdata;
    end
  end

  sdgcp_parser #(
    .PIN_COUNT (PIN_COUNT)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .rx_byte    (in_chan.rx_byte),
    .fw_version (version_r),
    .burst      (burst_nxt)
  );

  // Move one owed response into the output register whenever it is empty or drains
  assign load       = busy_r && (!out_valid_r || out_chan.ready);
  assign final_load = load && (idx_r == (burst_r.len - 3'd1));

  // Take a new byte when idle or while the previous burst hands over its final response
  assign in_chan.ready = !busy_r || final_load;
  assign in_accept     = in_chan.valid && in_chan.ready;

  assign sel_byte = burst_r.use_id ? ID_TEXT[idx_r] : burst_r.bytes[idx_r[1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (in_accept) begin
        // A byte with no response leaves the stage free
        busy_r <= (burst_nxt.len != 3'd0);
        idx_r  <= '0;
      end else if (final_load) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else if (load) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  // Burst payload: hold until the next accepted byte
  always_ff @(posedge clk) begin
    if (in_accept) begin
      burst_r <= burst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= sel_byte;
      // The DAC write rides on the first response of its burst only
      out_dac_r   <= burst_r.dac_write && (idx_r == 3'd0);
      out_chan_r  <= (idx_r == 3'd0) ? burst_r.dac_channel : 8'd0;
      out_value_r <= (idx_r == 3'd0) ? burst_r.dac_value : 16'd0;
      out_pins_r  <= burst_r.pins;
      out_last_r  <= (idx_r == (burst_r.len - 3'd1));
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.tx_valid    = 1'b1;
  assign out_chan.tx_byte     = out_byte_r;
  assign out_chan.dac_write   = out_dac_r;
  assign out_chan.dac_channel = out_chan_r;
  assign out_chan.dac_value   = out_value_r;
  assign out_chan.pin_pattern = out_pins_r;
  assign out_chan.last        = out_last_r;

endmodule
